>>> sv/dwsc_pkg.sv
package dwsc_pkg;

   localparam int COUNT_W = 32;
   localparam int MS_W = 16;
   localparam int SPEED_W = 20;
   localparam int ERR_W = 21;
   localparam int GAIN_W = 16;
   localparam int PWM_MAX_DEFAULT = 511;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // numerator scale: 60000 * 10 * 256
   localparam logic [27:0] RPM_SCALE = 28'd153600000;
   localparam logic [19:0] SPEED_MAX = 20'h7FFFF;
   localparam logic [19:0] SPEED_MIN_MAG = 20'h80000;

   // quotient bits produced by the divider (enough to detect saturation)
   localparam int QUOT_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_REV = 2'd2;

   // gains handed to the lanes
   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] diff_gain;
      logic [GAIN_W-1:0] counts_per_rev;
   } gains_type;

   // control from sequencer to lanes
   typedef struct packed {
      logic start;
   } lane_ctrl_type;

endpackage

>>> sv/dwsc_lane.sv
// One wheel: speed measure (serial divider) then PD update.
module dwsc_lane #(
   parameter int PWM_MAX = dwsc_pkg::PWM_MAX_DEFAULT,
   parameter int LEVEL_W = $clog2(PWM_MAX + 1)
) (
   input  logic clock,
   input  logic reset,
   input  dwsc_pkg::lane_ctrl_type ctrl,
   input  dwsc_pkg::gains_type gains,
   input  logic [dwsc_pkg::COUNT_W-1:0] count,
   input  logic [dwsc_pkg::MS_W-1:0] elapsed_ms,
   input  logic signed [dwsc_pkg::SPEED_W-1:0] target,
   output logic done,
   output logic [LEVEL_W-1:0] level,
   output logic signed [dwsc_pkg::SPEED_W-1:0] speed
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_ERR  = 7'b0001000,
      S_PD   = 7'b0010000,
      S_PROD = 7'b0100000,
      S_UPD  = 7'b1000000
   } state_type;

   localparam int NUM_W = 60;
   localparam int DEN_W = 32;
   localparam int STEP_W = $clog2(NUM_W + 1);

   state_type state_ff, state_in;
   logic [dwsc_pkg::COUNT_W-1:0] prev_count_ff, prev_count_in;
   logic signed [dwsc_pkg::ERR_W-1:0] prev_err_ff, prev_err_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic neg_ff, neg_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0] rem_ff, rem_in;
   logic [dwsc_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [dwsc_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic signed [dwsc_pkg::ERR_W-1:0] err_ff, err_in;
   logic signed [39:0] psum_ff, psum_in;
   logic signed [39:0] dsum_ff, dsum_in;

   logic [dwsc_pkg::COUNT_W-1:0] delta;
   logic [dwsc_pkg::COUNT_W-1:0] mag;
   logic [DEN_W:0] rem_sh;
   logic signed [40:0] total;
   logic [40:0] tmag;
   logic signed [21:0] term;
   logic signed [22:0] sum;
   logic signed [dwsc_pkg::ERR_W:0] derr;
   logic [dwsc_pkg::SPEED_W:0] tabs, mabs;
   logic signed [39:0] pprod, dprod;

   assign delta = count - prev_count_ff;
   assign mag = delta[dwsc_pkg::COUNT_W-1] ? (~delta + 1'b1) : delta;
   assign rem_sh = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
   assign tabs = target[dwsc_pkg::SPEED_W-1] ?
      (~{target[dwsc_pkg::SPEED_W-1], target} + 1'b1) : {1'b0, target};
   assign mabs = speed_ff[dwsc_pkg::SPEED_W-1] ?
      (~{speed_ff[dwsc_pkg::SPEED_W-1], speed_ff} + 1'b1) : {1'b0, speed_ff};
   assign derr = {err_ff[dwsc_pkg::ERR_W-1], err_ff}
      - {prev_err_ff[dwsc_pkg::ERR_W-1], prev_err_ff};

   // gain products, registered before the final add
   assign pprod = 40'($signed({1'b0, gains.prop_gain}) * err_ff);
   assign dprod = 40'($signed({1'b0, gains.diff_gain}) * derr);

   // correction truncated toward zero, then added to the level
   assign total = {psum_ff[39], psum_ff} + {dsum_ff[39], dsum_ff};
   assign tmag = total[40] ? (~total + 1'b1) : total;
   assign term = total[40] ? -$signed({1'b0, tmag[40:20]}) : $signed({1'b0, tmag[40:20]});
   assign sum = $signed({{(23-LEVEL_W){1'b0}}, level_ff}) + 23'(term);

   always_comb begin
      state_in = state_ff;
      prev_count_in = prev_count_ff;
      prev_err_in = prev_err_ff;
      level_in = level_ff;
      neg_in = neg_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      speed_in = speed_ff;
      err_in = err_ff;
      psum_in = psum_ff;
      dsum_in = dsum_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               neg_in = delta[dwsc_pkg::COUNT_W-1];
               num_in = {28'd0, mag};
               den_in = 32'(elapsed_ms * gains.counts_per_rev);
               prev_count_in = count;
               state_in = S_MUL;
            end
         end
         // numerator product: 32 x 28 bits
         S_MUL: begin
            num_in = NUM_W'(num_ff[31:0] * dwsc_pkg::RPM_SCALE);
            rem_in = '0;
            quot_in = '0;
            step_in = '0;
            state_in = (den_ff == '0) ? S_ERR : S_DIV;
            if (den_ff == '0) speed_in = '0;
         end
         // restoring divide, one bit per cycle
         S_DIV: begin
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quot_in = {quot_ff[dwsc_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quot_in = {quot_ff[dwsc_pkg::QUOT_W-2:0], 1'b0};
            end
            // sticky saturation when quotient leaves the window
            if (quot_ff[dwsc_pkg::QUOT_W-1]) quot_in = '1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) state_in = S_ERR;
         end
         S_ERR: begin
            if (den_ff != '0) begin
               if (neg_ff) begin
                  if (quot_ff > {4'd0, dwsc_pkg::SPEED_MIN_MAG})
                     speed_in = $signed(dwsc_pkg::SPEED_MIN_MAG);
                  else
                     speed_in = -$signed(quot_ff[dwsc_pkg::SPEED_W-1:0]);
               end else begin
                  if (quot_ff > {4'd0, dwsc_pkg::SPEED_MAX})
                     speed_in = $signed(dwsc_pkg::SPEED_MAX);
                  else
                     speed_in = $signed(quot_ff[dwsc_pkg::SPEED_W-1:0]);
               end
            end
            state_in = S_PD;
         end
         S_PD: begin
            err_in = $signed(tabs) - $signed(mabs);
            state_in = S_PROD;
         end
         S_PROD: begin
            psum_in = pprod;
            dsum_in = dprod;
            state_in = S_UPD;
         end
         // clamp level to 0..PWM_MAX and keep the error
         S_UPD: begin
            prev_err_in = err_ff;
            if (sum >= 23'(PWM_MAX)) level_in = LEVEL_W'(PWM_MAX);
            else if (sum <= 23'sd0) level_in = '0;
            else level_in = LEVEL_W'(sum);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_count_ff <= '0;
         prev_err_ff <= '0;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         prev_count_ff <= prev_count_in;
         prev_err_ff <= prev_err_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      speed_ff <= speed_in;
      err_ff <= err_in;
      psum_ff <= psum_in;
      dsum_ff <= dsum_in;
   end

   assign done = (state_ff == S_UPD);
   assign level = level_ff;
   assign speed = speed_ff;

endmodule

>>> sv/dual_wheel_speed_pd_controller.sv
// Channel  | Ports        | Contents
// request  | req_*        | counts, elapsed ms, targets
// response | rsp_*        | duty, reverse, speed per wheel
// config   | csr_*        | gains, counts per revolution
// A response is offered once its request transaction has run through both
// wheel lanes; each lane's wait is set by its 60-step bit-serial divider,
// skipped when the divisor is zero, and both lanes run side by side. The next
// request is taken in the cycle after the response loads the output register.
// Reset is synchronous, active high; it clears kept counts, errors, levels.
// A held response does not stall the lanes; a finished tick then waits in the
// lanes and holds off the request side until the output register frees.
module dual_wheel_speed_pd_controller #(
   parameter int PWM_MAX = dwsc_pkg::PWM_MAX_DEFAULT,
   parameter int LEVEL_W = $clog2(PWM_MAX + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // right_count, left_count, elapsed_ms, right_target, left_target
   input  logic [119:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // right_duty, right_reverse, right_speed, left_duty, left_reverse, left_speed
   output logic [63:0] rsp_tdata,
   input  logic csr_we,
   input  logic [dwsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dwsc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   dwsc_pkg::gains_type gains_ff;
   dwsc_pkg::lane_ctrl_type ctrl;
   logic busy_ff;
   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic [1:0] done;
   logic [LEVEL_W-1:0] rlevel, llevel;
   logic signed [19:0] rspeed, lspeed;
   logic signed [19:0] rt_ff, lt_ff;
   logic [8:0] rduty, lduty;
   logic merge_ff;
   logic ready_ff;
   logic load_rsp;

   assign req_tready = !busy_ff;
   assign ctrl.start = req_tvalid && req_tready;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop_gain <= 16'd2048;
         gains_ff.diff_gain <= 16'd41;
         gains_ff.counts_per_rev <= 16'd9984;
      end else if (csr_we) begin
         if (csr_index == dwsc_pkg::CSR_PROP_GAIN) gains_ff.prop_gain <= csr_wdata;
         else if (csr_index == dwsc_pkg::CSR_DIFF_GAIN) gains_ff.diff_gain <= csr_wdata;
         else if (csr_index == dwsc_pkg::CSR_COUNTS_PER_REV)
            gains_ff.counts_per_rev <= csr_wdata;
      end
   end

   dwsc_lane #(.PWM_MAX(PWM_MAX), .LEVEL_W(LEVEL_W)) u_right (
      .clock, .reset, .ctrl, .gains(gains_ff),
      .count(req_tdata[31:0]), .elapsed_ms(req_tdata[79:64]),
      .target(ctrl.start ? $signed(req_tdata[99:80]) : rt_ff),
      .done(done[0]), .level(rlevel), .speed(rspeed));

   dwsc_lane #(.PWM_MAX(PWM_MAX), .LEVEL_W(LEVEL_W)) u_left (
      .clock, .reset, .ctrl, .gains(gains_ff),
      .count(req_tdata[63:32]), .elapsed_ms(req_tdata[79:64]),
      .target(ctrl.start ? $signed(req_tdata[119:100]) : lt_ff),
      .done(done[1]), .level(llevel), .speed(lspeed));

   // merge: lane levels land in the cycle after done and stay until next start
   assign rduty = (rt_ff == 0) ? 9'd0 : 9'(rlevel);
   assign lduty = (lt_ff == 0) ? 9'd0 : 9'(llevel);
   assign load_rsp = (merge_ff || ready_ff) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rt_ff <= $signed(req_tdata[99:80]);
         lt_ff <= $signed(req_tdata[119:100]);
      end
      if (load_rsp)
         rsp_data_ff <= {4'd0, lspeed, lt_ff[19], lduty, rspeed, rt_ff[19], rduty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         merge_ff <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         merge_ff <= done[0];
         if (ctrl.start) busy_ff <= 1'b1;
         else if (load_rsp) busy_ff <= 1'b0;
         // finished tick parked in the lanes while the output is full
         if (load_rsp) ready_ff <= 1'b0;
         else if (merge_ff) ready_ff <= 1'b1;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      done[0] == done[1]) else $error("lanes out of step");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready) else $error("request taken while busy");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");

endmodule
